// ===== rtl/cfsa_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfsa_pkg - shared types for the CAN frame sequence assembler
// Frame, status and per-frame decision types used by the step logic and top.
// ----------------------------------------------------------------------------
package cfsa_pkg;

   localparam int unsigned ID_W      = 29;
   localparam int unsigned BASE_W    = 11;
   localparam int unsigned DLC_W     = 4;
   localparam int unsigned DATA_W    = 64;
   localparam int unsigned WORD_W    = 32;
   localparam int unsigned NUM_WORDS = 6;
   localparam int unsigned REQ_DATA_W = 104;
   localparam int unsigned RSP_DATA_W = 256;

   localparam logic [DLC_W-1:0] FULL_DLC = 4'd8;

   typedef logic [1:0] pos_type;

   localparam pos_type POS_FIRST  = 2'd0;
   localparam pos_type POS_SECOND = 2'd1;
   localparam pos_type POS_LAST   = 2'd2;

   typedef enum logic [1:0] {
      ST_IGNORED    = 2'd0,
      ST_MALFORMED  = 2'd1,
      ST_INCOMPLETE = 2'd2,
      ST_COMPLETE   = 2'd3
   } status_type;

   typedef struct packed {
      logic [ID_W-1:0]   can_id;
      logic              is_extended;
      logic              is_remote;
      logic [DLC_W-1:0]  length_code;
      logic [DATA_W-1:0] payload;
   } frame_type;

   typedef struct packed {
      status_type status;
      logic       store;
      pos_type    pos;
      pos_type    next_pos;
      logic       inc_malformed;
      logic       inc_dropped;
   } decision_type;

endpackage

// ===== rtl/can_frame_sequence_assembler.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// can_frame_sequence_assembler - three-frame CAN sequence assembler
// Collects two words from each of three consecutive identifiers and reports
// each frame's status, the six words on completion, and running counters.
// ----------------------------------------------------------------------------
// a frame passes through the input register and then the result register
//   before rsp_tvalid rises; one frame per cycle sustained while rsp_tready
//   holds, set by the combinational step logic
// the input register refills while a result waits, so one stalled result
//   costs no throughput until both registers are full
// reset clears base_id, sequence position, counters and valid flags; held
//   words are not reset
module can_frame_sequence_assembler (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // can_id[28:0], length_code[32:29], payload[96:33], zero pad
   input  logic [cfsa_pkg::REQ_DATA_W-1:0]     req_tdata,
   // is_extended[0], is_remote[1]
   input  logic [1:0]                          req_tuser,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // word0..word5 [191:0], malformed_total[223:192], dropped_total[255:224]
   output logic [cfsa_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   // status[1:0]
   output logic [1:0]                          rsp_tuser,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [cfsa_pkg::BASE_W-1:0]         csr_data
);

   localparam int unsigned WW = cfsa_pkg::WORD_W;

   logic                          in_valid_ff;
   cfsa_pkg::frame_type           frame_ff;
   logic                          out_valid_ff;
   cfsa_pkg::status_type          status_ff;
   logic [WW-1:0]                 out_words_ff [cfsa_pkg::NUM_WORDS];
   logic [WW-1:0]                 held_ff      [cfsa_pkg::NUM_WORDS];
   logic [cfsa_pkg::BASE_W-1:0]   base_ff;
   cfsa_pkg::pos_type             next_pos_ff;
   cfsa_pkg::pos_type             next_pos_in;
   logic [WW-1:0]                 malformed_ff;
   logic [WW-1:0]                 malformed_in;
   logic [WW-1:0]                 dropped_ff;
   logic [WW-1:0]                 dropped_in;

   logic                          advance;
   logic                          process;
   logic                          complete;
   cfsa_pkg::decision_type        dec;
   logic [WW-1:0]                 lo_word;
   logic [WW-1:0]                 hi_word;

   assign csr_ready  = 1'b1;
   assign advance    = !out_valid_ff || rsp_tready;
   assign req_tready = !in_valid_ff || advance;
   assign process    = in_valid_ff && advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff <= '0;
      end else if (csr_valid && csr_ready) begin
         base_ff <= csr_data;
      end
   end

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         frame_ff.can_id      <= req_tdata[28:0];
         frame_ff.length_code <= req_tdata[32:29];
         frame_ff.payload     <= req_tdata[96:33];
         frame_ff.is_extended <= req_tuser[0];
         frame_ff.is_remote   <= req_tuser[1];
      end
   end

   cfsa_step u_step (
      .frame    (frame_ff),
      .base_id  (base_ff),
      .next_pos (next_pos_ff),
      .dec      (dec)
   );

   assign lo_word  = frame_ff.payload[WW-1:0];
   assign hi_word  = frame_ff.payload[2*WW-1:WW];
   assign complete = (dec.status == cfsa_pkg::ST_COMPLETE);

   always_comb begin
      next_pos_in  = next_pos_ff;
      malformed_in = malformed_ff;
      dropped_in   = dropped_ff;
      if (process) begin
         next_pos_in  = dec.next_pos;
         malformed_in = malformed_ff + WW'(dec.inc_malformed);
         dropped_in   = dropped_ff + WW'(dec.inc_dropped);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         next_pos_ff  <= cfsa_pkg::POS_FIRST;
         malformed_ff <= '0;
         dropped_ff   <= '0;
      end else begin
         next_pos_ff  <= next_pos_in;
         malformed_ff <= malformed_in;
         dropped_ff   <= dropped_in;
      end
   end

   // held words, two per position
   always_ff @(posedge clock) begin
      if (process && dec.store) begin
         unique case (dec.pos)
            cfsa_pkg::POS_FIRST: begin
               held_ff[0] <= lo_word;
               held_ff[1] <= hi_word;
            end
            cfsa_pkg::POS_SECOND: begin
               held_ff[2] <= lo_word;
               held_ff[3] <= hi_word;
            end
            cfsa_pkg::POS_LAST: begin
               held_ff[4] <= lo_word;
               held_ff[5] <= hi_word;
            end
            default: begin
            end
         endcase
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (process) begin
         status_ff <= dec.status;
         // last frame's words go straight from its payload
         out_words_ff[0] <= complete ? held_ff[0] : '0;
         out_words_ff[1] <= complete ? held_ff[1] : '0;
         out_words_ff[2] <= complete ? held_ff[2] : '0;
         out_words_ff[3] <= complete ? held_ff[3] : '0;
         out_words_ff[4] <= complete ? lo_word : '0;
         out_words_ff[5] <= complete ? hi_word : '0;
      end
   end

   // counters only move on a result transfer into the held result register,
   // so they always match the result on display
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tuser  = status_ff;
   assign rsp_tdata  = {dropped_ff, malformed_ff,
                        out_words_ff[5], out_words_ff[4], out_words_ff[3],
                        out_words_ff[2], out_words_ff[1], out_words_ff[0]};

   a_complete_restarts : assert property (@(posedge clock) disable iff (reset)
      (process && complete) |=> (next_pos_ff == cfsa_pkg::POS_FIRST))
      else $error("sequence position not cleared after completion");

   a_malformed_count : assert property (@(posedge clock) disable iff (reset)
      (process && dec.status == cfsa_pkg::ST_MALFORMED)
      |=> (malformed_ff == $past(malformed_ff) + WW'(1)))
      else $error("malformed counter did not step");

   a_ignored_quiet : assert property (@(posedge clock) disable iff (reset)
      (process && dec.status == cfsa_pkg::ST_IGNORED)
      |=> ($stable(dropped_ff) && $stable(malformed_ff) && $stable(next_pos_ff)))
      else $error("ignored frame changed sequence state");

   a_stall_full : assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> (in_valid_ff && out_valid_ff && !rsp_tready))
      else $error("input stalled with room in the pipeline");

endmodule

// ===== rtl/cfsa_step.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfsa_step - per-frame classification
// Range check, format check and sequence-order check for one frame, giving
// the status, store control and counter updates.
// ----------------------------------------------------------------------------
module cfsa_step (
   input  cfsa_pkg::frame_type          frame,
   input  logic [cfsa_pkg::BASE_W-1:0]  base_id,
   input  cfsa_pkg::pos_type            next_pos,
   output cfsa_pkg::decision_type       dec
);

   logic [cfsa_pkg::BASE_W:0] base_lo;
   logic [cfsa_pkg::BASE_W:0] base_hi;
   logic                      in_range;
   logic                      bad_format;
   cfsa_pkg::pos_type         pos;

   // base+2 formed one bit wider so it never wraps
   assign base_lo  = {1'b0, base_id};
   assign base_hi  = base_lo + (cfsa_pkg::BASE_W + 1)'(2);
   assign in_range = (frame.can_id >= cfsa_pkg::ID_W'(base_lo))
                  && (frame.can_id <= cfsa_pkg::ID_W'(base_hi));
   assign bad_format = frame.is_extended || frame.is_remote
                    || (frame.length_code != cfsa_pkg::FULL_DLC);
   // distance is 0..2 when in range, so two low bits suffice
   assign pos = frame.can_id[1:0] - base_id[1:0];

   always_comb begin
      dec = '0;
      dec.status   = cfsa_pkg::ST_IGNORED;
      dec.pos      = pos;
      dec.next_pos = next_pos;
      if (!in_range) begin
         dec.status = cfsa_pkg::ST_IGNORED;
      end else if (bad_format) begin
         dec.status        = cfsa_pkg::ST_MALFORMED;
         dec.inc_malformed = 1'b1;
         dec.inc_dropped   = (next_pos != cfsa_pkg::POS_FIRST);
         dec.next_pos      = cfsa_pkg::POS_FIRST;
      end else if (pos != next_pos && pos != cfsa_pkg::POS_FIRST) begin
         dec.status      = cfsa_pkg::ST_INCOMPLETE;
         dec.inc_dropped = 1'b1;
         dec.next_pos    = cfsa_pkg::POS_FIRST;
      end else begin
         // restart at position 0 drops an open sequence
         dec.store       = 1'b1;
         dec.inc_dropped = (pos != next_pos);
         if (pos == cfsa_pkg::POS_LAST) begin
            dec.status   = cfsa_pkg::ST_COMPLETE;
            dec.next_pos = cfsa_pkg::POS_FIRST;
         end else begin
            dec.status   = cfsa_pkg::ST_INCOMPLETE;
            dec.next_pos = pos + 2'd1;
         end
      end
   end

endmodule
